/* design/spd_pkg.sv */
// Package for the stream pattern deleter: widths, register indexes, reset values,
// the decision record passed from the matcher to the sequencer, and a byte select.
// No dependencies.
package spd_pkg;

	localparam int BYTE_W          = 8;
	localparam int PAT_W           = 64;
	localparam int LEN_W           = 4;
	localparam int CNT_W           = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int SPD_MAX_PATTERN = 8;

	localparam logic [PAT_W-1:0] PATTERN_RESET = 64'h002C_6469_7573_6F6E;
	localparam logic [LEN_W-1:0] LENGTH_RESET  = 4'd7;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'd1;

	// What one accepted byte causes: a flushed prefix, maybe the byte itself,
	// a second flushed prefix on the final byte, and the new match count.
	typedef struct packed {
		logic [CNT_W-1:0] cnt1;
		logic             emit_b;
		logic [CNT_W-1:0] cnt2;
		logic [CNT_W-1:0] count_next;
	} spd_decision_t;

	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
		input logic [CNT_W-1:0] idx);
		pat_byte = pat[idx*BYTE_W +: BYTE_W];
	endfunction

endpackage

/* design/spd_match.sv */
// Match decision for one input byte of the stream pattern deleter.
// Depends on spd_pkg.
module spd_match import spd_pkg::*; #(
	parameter int MAX_PATTERN = SPD_MAX_PATTERN
) (
	input  logic [PAT_W-1:0]  pattern,
	input  logic [LEN_W-1:0]  length_raw,
	input  logic [CNT_W-1:0]  count,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              stream_last,
	output spd_decision_t     decision
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] count_ext;
	logic [LEN_W-1:0] count_inc;
	logic             hit;
	logic [CNT_W-1:0] count_mid;

	always_comb begin
		if (length_raw == '0) begin
			len_eff = LEN_W'(1);
		end else if (length_raw > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = length_raw;
		end
	end

	assign count_ext = LEN_W'(count);
	assign count_inc = count_ext + LEN_W'(1);
	assign hit = (count_ext < len_eff) && (in_byte == pat_byte(pattern, count));

	always_comb begin
		decision = '0;
		if (hit) begin
			count_mid = (count_inc >= len_eff) ? '0 : count_inc[CNT_W-1:0];
		end else begin
			decision.cnt1 = count;
			if (in_byte == pat_byte(pattern, '0)) begin
				// A one-byte pattern completes on the spot and nothing is held.
				count_mid = (len_eff <= LEN_W'(1)) ? '0 : CNT_W'(1);
			end else begin
				count_mid = '0;
				decision.emit_b = 1'b1;
			end
		end
		if (stream_last) begin
			decision.cnt2       = count_mid;
			decision.count_next = '0;
		end else begin
			decision.count_next = count_mid;
		end
	end

endmodule

/* design/stream_pattern_deleter_top.sv */
// Stream pattern deleter: deletes every occurrence of a configured byte pattern.
// Takes one byte, then emits its results one per cycle from an output register
// while the output does not stall. An item with no result leaves the block ready
// for the next byte; else the sequencer walks the held prefix byte by byte and takes
// no new byte until its last result is loaded. Acceptance updates the state register first.
// Reset (arst_n low) clears the match count and loads the default pattern and length.
module stream_pattern_deleter_top import spd_pkg::*; #(
	parameter int MAX_PATTERN = SPD_MAX_PATTERN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] in_byte
	input  logic                 s_tlast,   // stream_last
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_byte
	output logic                 m_tlast,   // run_last
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data
);

	localparam int PB_W = MAX_PATTERN * BYTE_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FLUSH1 = 2'd1;
	localparam logic [1:0] ST_BYTE   = 2'd2;
	localparam logic [1:0] ST_FLUSH2 = 2'd3;

	logic [PB_W-1:0]   pattern_q;
	logic [LEN_W-1:0]  length_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt1_q;
	logic              emitb_q;
	logic [CNT_W-1:0]  cnt2_q;
	logic [CNT_W-1:0]  idx_q;
	logic [BYTE_W-1:0] byte_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic [PAT_W-1:0]  pattern_full;
	spd_decision_t     dec;
	logic              in_acc;
	logic              emit_en;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;
	logic [1:0]        state_after;
	logic [CNT_W-1:0]  idx_after;

	assign pattern_full = PAT_W'(pattern_q);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign emit_en   = (state_q != ST_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_byte_q;
	assign m_tlast   = out_last_q;

	spd_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
		.pattern     (pattern_full),
		.length_raw  (length_q),
		.count       (count_q),
		.in_byte     (s_tdata),
		.stream_last (s_tlast),
		.decision    (dec)
	);

	// Next result and the sequencer step that follows it.
	always_comb begin
		emit_byte   = pat_byte(pattern_full, idx_q);
		emit_last   = 1'b0;
		state_after = state_q;
		idx_after   = idx_q;
		case (state_q)
			ST_FLUSH1: begin
				if (idx_q == cnt1_q - CNT_W'(1)) begin
					emit_last = !emitb_q && (cnt2_q == '0);
					idx_after = '0;
					if (emitb_q) begin
						state_after = ST_BYTE;
					end else if (cnt2_q != '0) begin
						state_after = ST_FLUSH2;
					end else begin
						state_after = ST_IDLE;
					end
				end else begin
					idx_after = idx_q + CNT_W'(1);
				end
			end
			ST_BYTE: begin
				emit_byte   = byte_q;
				emit_last   = (cnt2_q == '0);
				idx_after   = '0;
				state_after = (cnt2_q != '0) ? ST_FLUSH2 : ST_IDLE;
			end
			ST_FLUSH2: begin
				if (idx_q == cnt2_q - CNT_W'(1)) begin
					emit_last   = 1'b1;
					idx_after   = '0;
					state_after = ST_IDLE;
				end else begin
					idx_after = idx_q + CNT_W'(1);
				end
			end
			default: begin
				idx_after = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= PATTERN_RESET[PB_W-1:0];
			length_q    <= LENGTH_RESET;
			count_q     <= '0;
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PATTERN: pattern_q <= cfg_data[PB_W-1:0];
					REG_LENGTH:  length_q  <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				count_q <= dec.count_next;
				idx_q   <= '0;
				if (dec.cnt1 != '0) begin
					state_q <= ST_FLUSH1;
				end else if (dec.emit_b) begin
					state_q <= ST_BYTE;
				end else if (dec.cnt2 != '0) begin
					state_q <= ST_FLUSH2;
				end
			end else if (emit_en) begin
				state_q <= state_after;
				idx_q   <= idx_after;
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnt1_q  <= dec.cnt1;
			emitb_q <= dec.emit_b;
			cnt2_q  <= dec.cnt2;
			byte_q  <= s_tdata;
		end
		if (emit_en) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

endmodule

/* design/spd_checker.sv */
// Port-level checks for the stream pattern deleter, attached by bind.
// Depends on spd_pkg and stream_pattern_deleter_top.
module spd_checker import spd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [7:0]           s_tdata,
	input logic                 s_tlast,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [7:0]           m_tdata,
	input logic                 m_tlast,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [PAT_W-1:0]     cfg_data
);

	// While a result that is not the last of its item waits, no new byte is taken.
	a_no_take_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input taken while a transaction run is unfinished");

	// A busy block with an empty output produces a result in the next cycle.
	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready && !m_tvalid) |=> m_tvalid)
		else $error("busy sequencer left the output empty");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output transaction changed");

	// A waiting input transaction holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tlast)))
		else $error("waiting input transaction changed");

	// Register writes arrive only on a quiet block and carry known values.
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |->
			(s_tready && !m_tvalid && !$isunknown({cfg_index, cfg_data})))
		else $error("register write while a transaction was in flight");

endmodule

bind stream_pattern_deleter_top spd_checker u_spd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.s_tlast   (s_tlast),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

/* test/stream_pattern_deleter_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stream_pattern_deleter_top: feeds byte streams and compares
// every output transaction with a behavioral prediction of the pattern deletion.
// Depends on spd_pkg and the design top level only.
module stream_pattern_deleter_top_tb;
	import spd_pkg::*;

	localparam int unsigned IDLE_PCT      = 17;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} in_byte_t;

	typedef struct {
		logic [7:0] data;
		logic       run_end;
	} out_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN;
	logic [PAT_W-1:0]     cfg_data = '0;

	// Stream items waiting for the driver, and output bytes still due from the block.
	in_byte_t    bytes_to_send[$];
	out_byte_t   bytes_due[$];
	in_byte_t    next_item;
	out_byte_t   oldest_due;

	// Predicted register contents and number of pattern bytes being held.
	logic [PAT_W-1:0] p_pattern = PATTERN_RESET;
	logic [LEN_W-1:0] p_length = LENGTH_RESET;
	int unsigned      p_held = 0;

	int unsigned cycle_cnt = 0;
	int unsigned outstanding = 0;
	int unsigned accepted = 0;
	int unsigned finals = 0;
	int unsigned checked = 0;
	int unsigned cfg_writes = 0;
	int unsigned err_cnt = 0;
	logic        calm;

	stream_pattern_deleter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// A long window in every stretch of cycles where neither side idles.
	assign calm = (cycle_cnt % 2500) >= 1800;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still due", cycle_cnt, bytes_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int unsigned eff_len();
		if (p_length == 0)
			return 1;
		if (p_length > SPD_MAX_PATTERN)
			return SPD_MAX_PATTERN;
		return p_length;
	endfunction

	function automatic logic [7:0] pattern_char(input int unsigned idx);
		return p_pattern[(idx % 8) * 8 +: 8];
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		out_byte_t o;
		o.data = b;
		o.run_end = 1'b0;
		bytes_due.push_back(o);
	endfunction

	// Held bytes are always the leading pattern bytes, taken from the current pattern.
	function automatic void flush_held();
		int unsigned i;
		for (i = 0; i < p_held; i++)
			emit_byte(pattern_char(i));
		p_held = 0;
	endfunction

	function automatic void predict_deletion(input logic [7:0] b, input logic fin);
		int unsigned len;
		int unsigned due_before;
		len = eff_len();
		due_before = bytes_due.size();
		if (p_held < len && b == pattern_char(p_held)) begin
			p_held++;
			if (p_held >= len)
				p_held = 0;
		end else begin
			flush_held();
			if (b == pattern_char(0))
				p_held = (len == 1) ? 0 : 1;
			else
				emit_byte(b);
		end
		if (fin)
			flush_held();
		if (bytes_due.size() > due_before)
			bytes_due[bytes_due.size() - 1].run_end = 1'b1;
	endfunction

	// Driver: predicts at each accepted transaction, then refills the slot or idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_deletion(s_tdata, s_tlast);
				outstanding--;
				accepted++;
				if (s_tlast)
					finals++;
			end
			if (!s_tvalid || s_tready) begin
				if (bytes_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_item = bytes_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_item.data;
					s_tlast <= next_item.fin;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output transaction against the oldest byte due.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bytes_due.size() == 0) begin
					$error("unexpected output: out_byte %02h run_last %0b", m_tdata, m_tlast);
					err_cnt++;
				end else begin
					oldest_due = bytes_due.pop_front();
					checked++;
					if (m_tdata !== oldest_due.data) begin
						$error("out_byte: expected %02h, actual %02h", oldest_due.data, m_tdata);
						err_cnt++;
					end
					if (m_tlast !== oldest_due.run_end) begin
						$error("run_last: expected %0b, actual %0b", oldest_due.run_end, m_tlast);
						err_cnt++;
					end
				end
			end
			m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic fin);
		in_byte_t it;
		it.data = b;
		it.fin = fin;
		outstanding++;
		bytes_to_send.push_back(it);
	endtask

	// Waits until every byte has been taken and answered, then lets the block settle.
	task automatic wait_idle();
		while (outstanding != 0 || bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_PATTERN)
			p_pattern = data;
		else
			p_length = data[LEN_W-1:0];
		cfg_writes++;
	endtask

	// The length register only looks at its low bits, so the rest carries noise.
	task automatic set_pattern(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len);
		logic [PAT_W-1:0] noise;
		noise = {$urandom, $urandom};
		write_reg(REG_PATTERN, pat);
		write_reg(REG_LENGTH, {noise[PAT_W-1:LEN_W], len});
	endtask

	function automatic logic [7:0] noise_byte(input bit narrow);
		if (narrow && $urandom_range(0, 3) != 0)
			return 8'h61 + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic pick_fin();
		return $urandom_range(0, 19) == 0;
	endfunction

	// Patterns over a tiny alphabet make prefixes overlap and restart often.
	function automatic logic [PAT_W-1:0] narrow_pattern();
		logic [PAT_W-1:0] pat;
		int unsigned i;
		for (i = 0; i < 8; i++)
			pat[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, 2));
		return pat;
	endfunction

	// Mostly runs into the pattern, full or cut short, with noise and stray pattern bytes.
	task automatic queue_random(input int unsigned n, input bit narrow);
		int unsigned added;
		int unsigned len;
		int unsigned k;
		int unsigned r;
		int unsigned i;
		len = eff_len();
		added = 0;
		while (added < n) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				k = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
				for (i = 0; i < k; i++)
					queue_byte(pattern_char(i), pick_fin());
				added += k;
				if (k < len && $urandom_range(0, 1) == 1) begin
					queue_byte(noise_byte(narrow), pick_fin());
					added++;
				end
			end else if (r < 80) begin
				queue_byte(noise_byte(narrow), pick_fin());
				added++;
			end else begin
				queue_byte(pattern_char($urandom_range(0, len - 1)), pick_fin());
				added++;
			end
		end
	endtask

	task automatic queue_text(input string txt, input logic fin_at_end);
		int i;
		for (i = 0; i < txt.len(); i++)
			queue_byte(txt[i], fin_at_end && i == txt.len() - 1);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Default pattern: a full match on the final byte, a broken prefix, a restart
		// on the first pattern byte, and a prefix flushed by the final byte.
		queue_text("nosuid,", 1'b1);
		queue_text("nox", 1'b0);
		queue_text("nno", 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);

		// Shorten the length while three bytes are held.
		queue_text("nos", 1'b0);
		write_reg(REG_LENGTH, 64'd2);
		queue_byte("x", 1'b0);
		// Change the pattern while its first byte is held.
		queue_byte("n", 1'b0);
		write_reg(REG_PATTERN, 64'h0000_0000_0000_717A);
		queue_byte("y", 1'b1);

		// One-byte pattern of a zero byte.
		set_pattern(64'h0, 4'd1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);

		set_pattern(PATTERN_RESET, LENGTH_RESET);
		queue_random(70, 1'b0);
		set_pattern({PAT_W{1'b1}}, 4'd8);
		queue_random(50, 1'b0);
		// Zero bytes as pattern characters, length above the maximum.
		set_pattern(64'h0, 4'd15);
		queue_random(50, 1'b0);
		set_pattern({$urandom, $urandom}, 4'($urandom_range(1, 8)));
		queue_random(60, 1'b0);
		set_pattern(narrow_pattern(), 4'($urandom_range(3, 8)));
		queue_random(70, 1'b1);
		// Zero length behaves as a one-byte pattern.
		set_pattern({$urandom, $urandom}, 4'd0);
		queue_random(40, 1'b0);
		set_pattern({$urandom, $urandom}, 4'($urandom_range(0, 15)));
		queue_random(70, 1'b0);
		set_pattern(narrow_pattern(), 4'd1);
		queue_random(40, 1'b1);

		wait_idle();
		repeat (20) @(posedge clk);

		$display("Run covered %0d input bytes (%0d marked final) and %0d output bytes,",
			accepted, finals, checked);
		$display("across %0d register writes with pattern lengths from 0 to 15.", cfg_writes);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
design/spd_pkg.sv
design/spd_match.sv
design/stream_pattern_deleter_top.sv
design/spd_checker.sv
test/stream_pattern_deleter_top_tb.sv
